/* design/peq_pkg.sv */
// Shared types, sizes and ring arithmetic for the priority exclusion queue.
package peq_pkg;

  localparam int DEPTH         = 32;
  localparam int PRIORITY_BITS = 8;
  localparam int DATA_BITS     = 32;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [PRIORITY_BITS-1:0] pri_t;
  typedef logic [DATA_BITS-1:0]     dat_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // One stored entry
  typedef struct packed {
    pri_t pri;
    dat_t dat;
  } entry_t;

  // Sequencer requests to the ring store; offsets are relative to the head
  typedef struct packed {
    logic   rd_en;
    idx_t   rd_off;
    logic   wr_en;
    idx_t   wr_off;
    entry_t wr_entry;
  } ring_ctrl_t;

  // base + off modulo DEPTH; both operands are below DEPTH
  function automatic idx_t ring_add(idx_t base, idx_t off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

/* design/priority_exclusion_queue_top.sv */
// Top level of the priority exclusion queue: command sequencer, ring store, result register.
//
//  channel  | ports                                              | handshake
//  ---------+----------------------------------------------------+--------------------------
//  command  | in_operation, in_priority_req, in_data_in          | start && !busy
//  result   | out_status, out_found_priority, out_found_data     | out_valid, one-cycle beat
//
// Insert, remove on an empty queue: busy stays low, result in the cycle after the beat.
// Remove: the search reads the entries one at a time, oldest first, through the single store read port
// and one comparator; a hit at position k (0 = oldest) then moves k older entries one slot,
// each read and then written back, and the hit is retired by advancing the head. A miss checks
// every stored entry. The result strobe follows the last busy cycle.
// Synchronous active-low reset empties the queue; store contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module priority_exclusion_queue_top
  import peq_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_operation,
  input  logic        [PRIORITY_BITS-1:0] in_priority_req,
  input  logic signed [DATA_BITS-1:0]     in_data_in,
  output logic                            out_valid,
  output logic        [1:0]               out_status,
  output logic        [PRIORITY_BITS-1:0] out_found_priority,
  output logic signed [DATA_BITS-1:0]     out_found_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_SHRD = 6'b001000,
    S_SHWR = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  idx_t       head_r, head_nxt;
  cnt_t       count_r, count_nxt;
  idx_t       k_r, k_nxt;
  pri_t       pri_r, pri_nxt;
  entry_t     hit_r, hit_nxt;
  logic       vld_r, vld_nxt;
  status_t    st_r, st_nxt;
  entry_t     res_r, res_nxt;
  ring_ctrl_t ctrl;
  entry_t     rd_entry;
  logic       accept;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  peq_ring u_ring (
    .clk      (clk),
    .head     (head_r),
    .ctrl     (ctrl),
    .rd_entry (rd_entry)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    pri_nxt   = pri_r;
    hit_nxt   = hit_r;
    vld_nxt   = 1'b0;
    st_nxt    = st_r;
    res_nxt   = res_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          pri_nxt = in_priority_req;
          k_nxt   = '0;
          res_nxt = '0;
          if (!in_operation) begin
            vld_nxt = 1'b1;
            if (count_r == CNT_W'(DEPTH)) begin
              st_nxt = ST_FULL;
            end else begin
              st_nxt            = ST_OK;
              ctrl.wr_en        = 1'b1;
              ctrl.wr_off       = count_r[IDX_W-1:0];
              ctrl.wr_entry.pri = in_priority_req;
              ctrl.wr_entry.dat = in_data_in;
              count_nxt         = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            vld_nxt = 1'b1;
            st_nxt  = ST_EMPTY;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_off = k_r;
        state_nxt   = S_CMP;
      end
      S_CMP: begin
        // one compare per entry, oldest first
        if (rd_entry.pri == pri_r) begin
          hit_nxt = rd_entry;
          if (k_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SHRD;
          end
        end else if (CNT_W'(k_r) + CNT_W'(1) == count_r) begin
          vld_nxt   = 1'b1;
          st_nxt    = ST_NOT_FOUND;
          res_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = S_RD;
        end
      end
      S_SHRD: begin
        ctrl.rd_en  = 1'b1;
        ctrl.rd_off = k_r - IDX_W'(1);
        state_nxt   = S_SHWR;
      end
      S_SHWR: begin
        // older entry moves one slot toward the tail
        ctrl.wr_en    = 1'b1;
        ctrl.wr_off   = k_r;
        ctrl.wr_entry = rd_entry;
        k_nxt         = k_r - IDX_W'(1);
        if (k_r == IDX_W'(1)) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_SHRD;
        end
      end
      S_FIN: begin
        head_nxt  = ring_add(head_r, IDX_W'(1));
        count_nxt = count_r - CNT_W'(1);
        vld_nxt   = 1'b1;
        st_nxt    = ST_OK;
        res_nxt   = hit_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    pri_r <= pri_nxt;
    hit_r <= hit_nxt;
    st_r  <= st_nxt;
    res_r <= res_nxt;
  end

  assign out_valid          = vld_r;
  assign out_status         = st_r;
  assign out_found_priority = res_r.pri;
  assign out_found_data     = res_r.dat;

  // an accepted beat either answers next cycle or keeps the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid || busy))
    else $error("accepted command neither answered nor in progress");

  // the shift never writes the head slot
  a_shift_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHWR) |-> (k_r != '0))
    else $error("shift write at head offset");

  // retiring a hit always reports success
  a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |=> (out_valid && out_status == ST_OK))
    else $error("hit retired without ok result");

  // failed commands carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> (out_found_priority == '0 && out_found_data == '0))
    else $error("nonzero fields on failed command");

  // fill level bounded by capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above capacity");

endmodule

/* design/peq_ring.sv */
// Ring store of queue entries: head-relative addressing, one read and one write port.
module peq_ring
  import peq_pkg::*;
(
  input  logic       clk,
  input  idx_t       head,
  input  ring_ctrl_t ctrl,
  output entry_t     rd_entry
);

  entry_t mem [DEPTH];
  idx_t   rd_addr;
  idx_t   wr_addr;

  // physical slots from head-relative offsets
  assign rd_addr = ring_add(head, ctrl.rd_off);
  assign wr_addr = ring_add(head, ctrl.wr_off);

  // storage with registered read data
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= ctrl.wr_entry;
    end
    if (ctrl.rd_en) begin
      rd_entry <= mem[rd_addr];
    end
  end

endmodule
